// File: rtl/rro_pkg.sv
// shared constants, types and the corner sort schedule of the overlap test
package rro_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 24;
  localparam int unsigned COEF_WIDTH_DEF  = 16;
  localparam int unsigned NCORNERS        = 4;
  localparam int unsigned MAC_DIGIT       = 4;
  localparam int unsigned SORT_STEPS      = 9;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_TEST  = 1'b1
  } op_e;

  localparam logic [3:0] HIT_NONE = 4'd8;

  // control of the shared multiply-accumulate unit
  typedef struct packed {
    logic start;
    logic clr;
    logic sub;
  } rro_mac_cmd_t;

  // one compare-exchange step of the corner ordering
  typedef struct packed {
    logic [1:0] lo;
    logic [1:0] hi;
    logic       by_x;
  } sort_pair_t;

  function automatic sort_pair_t sort_pair(logic [3:0] step);
    sort_pair_t p;
    p = '{lo: 2'd0, hi: 2'd1, by_x: 1'b0};
    unique case (step)
      4'd0: p = '{lo: 2'd0, hi: 2'd1, by_x: 1'b0};
      4'd1: p = '{lo: 2'd2, hi: 2'd3, by_x: 1'b0};
      4'd2: p = '{lo: 2'd0, hi: 2'd2, by_x: 1'b0};
      4'd3: p = '{lo: 2'd1, hi: 2'd3, by_x: 1'b0};
      4'd4: p = '{lo: 2'd1, hi: 2'd2, by_x: 1'b0};
      4'd5: p = '{lo: 2'd1, hi: 2'd2, by_x: 1'b1};
      4'd6: p = '{lo: 2'd2, hi: 2'd3, by_x: 1'b1};
      4'd7: p = '{lo: 2'd1, hi: 2'd2, by_x: 1'b1};
      4'd8: p = '{lo: 2'd2, hi: 2'd3, by_x: 1'b0};
      default: p = '{lo: 2'd0, hi: 2'd1, by_x: 1'b0};
    endcase
    return p;
  endfunction

endpackage

// File: rtl/rro_if.sv
// request and response channel interfaces of the overlap test
interface rro_req_if import rro_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned COEF_WIDTH  = COEF_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic        [COORD_WIDTH-1:0] width;
  logic        [COORD_WIDTH-1:0] height;
  logic signed [COEF_WIDTH-1:0]  coef_xx;
  logic signed [COEF_WIDTH-1:0]  coef_xy;
  logic signed [COEF_WIDTH-1:0]  coef_yx;
  logic signed [COEF_WIDTH-1:0]  coef_yy;
  logic signed [COORD_WIDTH-1:0] offset_x;
  logic signed [COORD_WIDTH-1:0] offset_y;

  modport source (output valid, op, width, height, coef_xx, coef_xy, coef_yx, coef_yy,
                  offset_x, offset_y, input ready);
  modport sink (input valid, op, width, height, coef_xx, coef_xy, coef_yx, coef_yy,
                offset_x, offset_y, output ready);
endinterface

interface rro_rsp_if;
  logic       valid;
  logic       ready;
  logic       overlap;
  logic [3:0] first_hit;

  modport source (output valid, overlap, first_hit, input ready);
  modport sink (input valid, overlap, first_hit, output ready);
endinterface

// File: rtl/rotated_rect_overlap_test.sv
// top level of the oriented rectangle corner containment test
//
// req_i takes one request per rectangle: op, size (unsigned Q.8), four signed
// Q2.(COEF_WIDTH-2) transform coefficients and a signed Q.8 offset. op store
// keeps the rectangle as the reference and gives no response; the block is
// ready again in the next cycle. op test checks the rectangle against the
// reference and gives one response on rsp_o: overlap, and first_hit naming the
// first corner found inside the other rectangle (8 for none).
// a test runs as a sequence on one shared multiply-accumulate unit that takes
// 4 multiplier bits a cycle. eight multiplies build the corners, S_CORN sums
// them, compare-exchange steps order the corners of each rectangle in turn, and
// then each edge check takes two multiplies. a test ends at the first corner
// found inside and checks every corner only when nothing hits.
// req_i.ready is high only while the sequencer is idle.
// the response sits in an output register; a new request is taken while it
// waits, and a finished test holds until rsp_o frees the register.
// reset clears the sequencer, drops rsp_o.valid and zeroes the reference,
// so a test before any store runs against a rectangle collapsed to the origin
module rotated_rect_overlap_test import rro_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned COEF_WIDTH  = COEF_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rro_req_if.sink   req_i,
  rro_rsp_if.source rsp_o
);

  // corner coordinates are exact in units of 2^-(8+COEF_WIDTH-2)
  localparam int unsigned PW         = COORD_WIDTH + COEF_WIDTH + 2;
  localparam int unsigned OPW        = PW + 1;
  localparam int unsigned ACCW       = 2 * OPW + 1;
  localparam int unsigned FRAC_SHIFT = COEF_WIDTH - 2;

  typedef struct packed {
    logic signed [PW-1:0] x;
    logic signed [PW-1:0] y;
  } pt_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MISSUE,
    S_MWAIT,
    S_CORN,
    S_SLOAD,
    S_SORT,
    S_EISSUE,
    S_EWAIT,
    S_DONE
  } state_e;

  // order by y: higher y first, lower x on a tie
  function automatic logic less_y(pt_t a, pt_t b);
    return (a.y == b.y) ? (a.x < b.x) : (a.y > b.y);
  endfunction

  // order by x: lower x first, higher y on a tie
  function automatic logic less_x(pt_t a, pt_t b);
    return (a.x == b.x) ? (a.y > b.y) : (a.x < b.x);
  endfunction

  state_e state_q;

  // reference rectangle, zero after reset
  logic        [COORD_WIDTH-1:0] ref_w_q, ref_h_q;
  logic signed [COEF_WIDTH-1:0]  ref_coef_q [NCORNERS];
  logic signed [COORD_WIDTH-1:0] ref_off_q  [2];

  // rectangle under test
  logic        [COORD_WIDTH-1:0] tst_w_q, tst_h_q;
  logic signed [COEF_WIDTH-1:0]  tst_coef_q [NCORNERS];
  logic signed [COORD_WIDTH-1:0] tst_off_q  [2];

  // products: index bit 2 picks the rectangle (0 reference, 1 tested),
  // low bits xx*w, yx*w, xy*h, yy*h
  logic signed [PW-1:0] prod_q [2*NCORNERS];
  pt_t raw_q    [2][NCORNERS];
  pt_t sorted_q [2][NCORNERS];
  pt_t srt_q    [NCORNERS];
  pt_t corner_d [2][NCORNERS];

  // sequencer counters
  logic [2:0] mi_q;
  logic [3:0] step_q;
  logic       srect_q;
  logic       ph_q;
  logic [1:0] pk_q;
  logic [1:0] pe_q;
  logic       half_q;

  // verdict of the running test, kept apart from the response register
  logic [3:0] hit_q;

  logic       out_valid_q;
  logic       overlap_q;
  logic [3:0] first_hit_q;

  // shared unit
  rro_mac_cmd_t          mac_cmd;
  logic signed [OPW-1:0] mac_a, mac_b;
  logic                  mac_busy;
  logic signed [ACCW-1:0] mac_acc;

  logic req_fire;
  logic mac_done;

  assign req_i.ready     = (state_q == S_IDLE);
  assign req_fire        = req_i.valid && req_i.ready;
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.overlap   = overlap_q;
  assign rsp_o.first_hit = first_hit_q;
  assign mac_done        = !mac_busy;

  // operand selection for the shared unit
  logic [1:0]                    mfield;
  logic [1:0]                    cidx;
  logic signed [COEF_WIDTH-1:0]  sel_coef;
  logic        [COORD_WIDTH-1:0] sel_size;
  pt_t edge_a, edge_b, probe;

  assign mfield = mi_q[1:0];
  assign cidx   = {mfield[0], mfield[1]};

  always_comb begin
    sel_coef = mi_q[2] ? tst_coef_q[cidx] : ref_coef_q[cidx];
    if (mfield[1]) begin
      sel_size = mi_q[2] ? tst_h_q : ref_h_q;
    end else begin
      sel_size = mi_q[2] ? tst_w_q : ref_w_q;
    end
    edge_a = sorted_q[ph_q][pe_q];
    edge_b = sorted_q[ph_q][pe_q + 2'd1];
    probe  = raw_q[!ph_q][pk_q];
  end

  always_comb begin
    mac_a   = '0;
    mac_b   = '0;
    mac_cmd = '0;
    unique case (state_q)
      S_MISSUE: begin
        mac_a   = OPW'(sel_coef);
        mac_b   = OPW'(sel_size);
        mac_cmd = '{start: 1'b1, clr: 1'b1, sub: 1'b0};
      end
      S_EISSUE: begin
        // edge value (bx-ax)*(py-ay) - (by-ay)*(px-ax)
        if (!half_q) begin
          mac_a   = OPW'(edge_b.x) - OPW'(edge_a.x);
          mac_b   = OPW'(probe.y) - OPW'(edge_a.y);
          mac_cmd = '{start: 1'b1, clr: 1'b1, sub: 1'b0};
        end else begin
          mac_a   = OPW'(edge_b.y) - OPW'(edge_a.y);
          mac_b   = OPW'(probe.x) - OPW'(edge_a.x);
          mac_cmd = '{start: 1'b1, clr: 1'b0, sub: 1'b1};
        end
      end
      default: begin
        mac_cmd = '0;
      end
    endcase
  end

  rro_mac #(
    .OPW  (OPW),
    .ACCW (ACCW)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mac_cmd),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .busy_o (mac_busy),
    .acc_o  (mac_acc)
  );

  // corners: offset plus the u and v products where the corner uses them
  always_comb begin
    for (int r = 0; r < 2; r++) begin
      for (int k = 0; k < NCORNERS; k++) begin
        logic signed [PW-1:0] bx, by;
        bx = (r == 0) ? (PW'(ref_off_q[0]) <<< FRAC_SHIFT)
                      : (PW'(tst_off_q[0]) <<< FRAC_SHIFT);
        by = (r == 0) ? (PW'(ref_off_q[1]) <<< FRAC_SHIFT)
                      : (PW'(tst_off_q[1]) <<< FRAC_SHIFT);
        corner_d[r][k].x = bx + ((k % 2 == 1) ? prod_q[4*r] : '0)
                              + ((k / 2 == 1) ? prod_q[4*r+2] : '0);
        corner_d[r][k].y = by + ((k % 2 == 1) ? prod_q[4*r+1] : '0)
                              + ((k / 2 == 1) ? prod_q[4*r+3] : '0);
      end
    end
  end

  // one compare-exchange of the corner ordering per cycle
  sort_pair_t sp;
  pt_t        sa, sb;
  logic       sswap;

  always_comb begin
    sp    = sort_pair(step_q);
    sa    = srt_q[sp.lo];
    sb    = srt_q[sp.hi];
    sswap = sp.by_x ? less_x(sb, sa) : less_y(sb, sa);
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    if (req_fire && (req_i.op == OP_TEST)) begin
      tst_w_q       <= req_i.width;
      tst_h_q       <= req_i.height;
      tst_coef_q[0] <= req_i.coef_xx;
      tst_coef_q[1] <= req_i.coef_xy;
      tst_coef_q[2] <= req_i.coef_yx;
      tst_coef_q[3] <= req_i.coef_yy;
      tst_off_q[0]  <= req_i.offset_x;
      tst_off_q[1]  <= req_i.offset_y;
    end
    if ((state_q == S_MWAIT) && mac_done) begin
      prod_q[mi_q] <= mac_acc[PW-1:0];
    end
    if (state_q == S_CORN) begin
      raw_q <= corner_d;
    end
    if (state_q == S_SLOAD) begin
      srt_q <= raw_q[srect_q];
    end
    if (state_q == S_SORT) begin
      if (step_q != 4'(SORT_STEPS)) begin
        if (sswap) begin
          srt_q[sp.lo] <= sb;
          srt_q[sp.hi] <= sa;
        end
      end else begin
        // the last two corners trade places to close the edge loop
        sorted_q[srect_q][0] <= srt_q[0];
        sorted_q[srect_q][1] <= srt_q[1];
        sorted_q[srect_q][2] <= srt_q[3];
        sorted_q[srect_q][3] <= srt_q[2];
      end
    end
  end

  // sequencer, reference state and response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ref_w_q     <= '0;
      ref_h_q     <= '0;
      ref_coef_q  <= '{default: '0};
      ref_off_q   <= '{default: '0};
      mi_q        <= '0;
      step_q      <= '0;
      srect_q     <= 1'b0;
      ph_q        <= 1'b0;
      pk_q        <= '0;
      pe_q        <= '0;
      half_q      <= 1'b0;
      hit_q       <= HIT_NONE;
      out_valid_q <= 1'b0;
      overlap_q   <= 1'b0;
      first_hit_q <= HIT_NONE;
    end else begin
      // a response handed over outside S_DONE frees the register
      if (rsp_o.valid && rsp_o.ready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            if (req_i.op == OP_STORE) begin
              ref_w_q       <= req_i.width;
              ref_h_q       <= req_i.height;
              ref_coef_q[0] <= req_i.coef_xx;
              ref_coef_q[1] <= req_i.coef_xy;
              ref_coef_q[2] <= req_i.coef_yx;
              ref_coef_q[3] <= req_i.coef_yy;
              ref_off_q[0]  <= req_i.offset_x;
              ref_off_q[1]  <= req_i.offset_y;
            end else begin
              mi_q    <= '0;
              state_q <= S_MISSUE;
            end
          end
        end
        S_MISSUE: begin
          state_q <= S_MWAIT;
        end
        S_MWAIT: begin
          if (mac_done) begin
            mi_q    <= mi_q + 1'b1;
            state_q <= (mi_q == 3'd7) ? S_CORN : S_MISSUE;
          end
        end
        S_CORN: begin
          srect_q <= 1'b0;
          state_q <= S_SLOAD;
        end
        S_SLOAD: begin
          step_q  <= '0;
          state_q <= S_SORT;
        end
        S_SORT: begin
          if (step_q != 4'(SORT_STEPS)) begin
            step_q <= step_q + 1'b1;
          end else if (!srect_q) begin
            srect_q <= 1'b1;
            state_q <= S_SLOAD;
          end else begin
            ph_q    <= 1'b0;
            pk_q    <= '0;
            pe_q    <= '0;
            half_q  <= 1'b0;
            state_q <= S_EISSUE;
          end
        end
        S_EISSUE: begin
          state_q <= S_EWAIT;
        end
        S_EWAIT: begin
          if (mac_done) begin
            if (!half_q) begin
              half_q  <= 1'b1;
              state_q <= S_EISSUE;
            end else begin
              half_q <= 1'b0;
              if (mac_acc[ACCW-1]) begin
                // negative edge value: this corner is outside
                pe_q <= '0;
                if (pk_q == 2'd3) begin
                  pk_q <= '0;
                  if (ph_q) begin
                    hit_q   <= HIT_NONE;
                    state_q <= S_DONE;
                  end else begin
                    ph_q    <= 1'b1;
                    state_q <= S_EISSUE;
                  end
                end else begin
                  pk_q    <= pk_q + 1'b1;
                  state_q <= S_EISSUE;
                end
              end else if (pe_q == 2'd3) begin
                hit_q   <= {1'b0, ph_q, pk_q};
                state_q <= S_DONE;
              end else begin
                pe_q    <= pe_q + 1'b1;
                state_q <= S_EISSUE;
              end
            end
          end
        end
        S_DONE: begin
          // hold until the response register is free
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q <= 1'b1;
            overlap_q   <= (hit_q != HIT_NONE);
            first_hit_q <= hit_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/rro_mac.sv
// shared signed multiply-accumulate unit, one 4-bit digit per cycle
module rro_mac import rro_pkg::*; #(
  parameter int unsigned OPW  = COORD_WIDTH_DEF + COEF_WIDTH_DEF + 3,
  parameter int unsigned ACCW = 2 * OPW + 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rro_mac_cmd_t           cmd_i,
  input  logic signed [OPW-1:0]  a_i,
  input  logic signed [OPW-1:0]  b_i,
  output logic                   busy_o,
  output logic signed [ACCW-1:0] acc_o
);

  localparam int unsigned STEPS = (OPW + MAC_DIGIT - 1) / MAC_DIGIT;
  localparam int unsigned CNTW  = $clog2(STEPS + 1);

  logic [CNTW-1:0] cnt_q;
  logic [ACCW-1:0] mcand_q;
  logic [ACCW-1:0] acc_q;
  logic [OPW-1:0]  mag_q;
  logic            neg_q;
  logic [OPW-1:0]  mag_start;
  logic [ACCW-1:0] part;

  assign mag_start = b_i[OPW-1] ? (~b_i + 1'b1) : b_i;
  assign part      = mcand_q * ACCW'(mag_q[MAC_DIGIT-1:0]);
  assign busy_o    = (cnt_q != '0);
  assign acc_o     = signed'(acc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.start) begin
      cnt_q <= CNTW'(STEPS);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mcand_q <= ACCW'(a_i);
      mag_q   <= mag_start;
      neg_q   <= b_i[OPW-1] ^ cmd_i.sub;
      if (cmd_i.clr) begin
        acc_q <= '0;
      end
    end else if (busy_o) begin
      acc_q   <= neg_q ? (acc_q - part) : (acc_q + part);
      mcand_q <= mcand_q << MAC_DIGIT;
      mag_q   <= mag_q >> MAC_DIGIT;
    end
  end

endmodule
